[hdl/sensor_sample_filter_chain_top_macros.svh]
// assertion helpers for the filter chain sequencer
`ifndef SENSOR_SAMPLE_FILTER_CHAIN_TOP_MACROS_SVH
`define SENSOR_SAMPLE_FILTER_CHAIN_TOP_MACROS_SVH

// clocked check, quiet while reset is active
`define SSFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds while reset is active
`define SSFC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/ssfc_pkg.sv]
`default_nettype none

package ssfc_pkg;

  // fixed field widths
  localparam int unsigned SmpW    = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned AlphaW  = 17;
  localparam int unsigned SumW    = 48;
  localparam int unsigned AluW    = 66;
  localparam int unsigned CfgIdxW = 4;

  // moving average weight of one in q1.16
  localparam logic [AlphaW-1:0] AlphaOne = AlphaW'(1) << (AlphaW - 1);

  // defaults for the top level parameters
  localparam int unsigned PassFirstDef    = 0;
  localparam int unsigned SampleBitsDef   = 32;
  localparam int unsigned FractionBitsDef = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SKIP_COUNT      = 4'd0,
    REG_AVERAGE_SAMPLES = 4'd1,
    REG_EMA_ALPHA       = 4'd2,
    REG_FIT_SLOPE       = 4'd3,
    REG_FIT_INTERCEPT   = 4'd4,
    REG_OFFSET_ADD      = 4'd5,
    REG_CLAMP_MIN       = 4'd6,
    REG_CLAMP_MAX       = 4'd7
  } cfg_reg_e;

  // live configuration as seen by the sequencer
  typedef struct packed {
    logic [LenW-1:0]   avg_len;
    logic [AlphaW-1:0] alpha;
    logic [SmpW-1:0]   slope;
    logic [SmpW-1:0]   intercept;
    logic [SmpW-1:0]   offset;
    logic [SmpW-1:0]   clamp_min;
    logic [SmpW-1:0]   clamp_max;
  } cfg_t;

  // counter reloads caused by a register write
  typedef struct packed {
    logic            skip_ld;
    logic [LenW-1:0] skip_val;
    logic            avg_ld;
    logic [LenW-1:0] avg_len;
  } cfg_ld_t;

  // request to the shared adder
  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
    logic            sub;
  } alu_req_t;

endpackage

`default_nettype wire

[hdl/sensor_sample_filter_chain_top.sv]
`default_nettype none

// Sensor conditioning chain: each signed q16.16 sample passes skip, block average, moving
// average, slope/intercept calibration, offset and min/max clamp, and a sample that
// survives yields one filtered value. Samples are taken with in_valid_i/in_stall_o and
// results leave through an output register on out_valid_o/out_stall_i, so the next sample
// is accepted while a result still waits. The sample arithmetic runs through one shared
// 66-bit adder under a sequencer, and in_stall_o stays high while it works: a sample that
// closes a block runs 32 divider steps for the mean when the block length is above one,
// 17 serial multiply steps for the moving average and 32 for the calibration.
// Configuration registers are written with cfg_valid_i and always ready; write them only
// while the chain is idle.
module sensor_sample_filter_chain_top #(
  parameter int unsigned PASS_FIRST    = ssfc_pkg::PassFirstDef,
  parameter int unsigned SAMPLE_BITS   = ssfc_pkg::SampleBitsDef,
  parameter int unsigned FRACTION_BITS = ssfc_pkg::FractionBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ssfc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ssfc_pkg::SmpW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [ssfc_pkg::SmpW-1:0] sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [ssfc_pkg::SmpW-1:0] filtered_value_o
);
  import ssfc_pkg::*;

  cfg_t            cfg;
  cfg_ld_t         cfg_ld;
  alu_req_t        alu_req;
  logic [AluW-1:0] alu_res;

  // configuration registers
  ssfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .cfg_ld_o    (cfg_ld)
  );

  // shared adder
  ssfc_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // sequencer and datapath
  ssfc_seq #(
    .PASS_FIRST    (PASS_FIRST),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_value_o (filtered_value_o),
    .cfg_i            (cfg),
    .cfg_ld_i         (cfg_ld),
    .alu_req_o        (alu_req),
    .alu_res_i        (alu_res)
  );

endmodule

`default_nettype wire

[hdl/ssfc_cfg_regs.sv]
`default_nettype none

module ssfc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ssfc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ssfc_pkg::SmpW-1:0]    cfg_data_i,
  output ssfc_pkg::cfg_t               cfg_o,
  output ssfc_pkg::cfg_ld_t            cfg_ld_o
);
  import ssfc_pkg::*;

  localparam cfg_t CfgReset = '{
    avg_len:   LenW'(1),
    alpha:     AlphaOne,
    slope:     32'h0001_0000,
    intercept: '0,
    offset:    '0,
    clamp_min: 32'h8000_0000,
    clamp_max: 32'h7fff_ffff
  };

  cfg_t              cfg_q, cfg_d;
  logic              wr;
  logic [LenW-1:0]   wlen;
  logic [AlphaW-1:0] walpha;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  // block length zero acts as one, weight above one acts as one
  assign wlen   = (cfg_data_i[LenW-1:0] == '0) ? LenW'(1) : cfg_data_i[LenW-1:0];
  assign walpha = (cfg_data_i[AlphaW-1:0] > AlphaOne) ? AlphaOne : cfg_data_i[AlphaW-1:0];

  // register decode
  always_comb begin
    cfg_d             = cfg_q;
    cfg_ld_o.skip_ld  = 1'b0;
    cfg_ld_o.skip_val = cfg_data_i[LenW-1:0];
    cfg_ld_o.avg_ld   = 1'b0;
    cfg_ld_o.avg_len  = wlen;
    if (wr) begin
      unique case (cfg_index_i)
        REG_SKIP_COUNT: begin
          cfg_ld_o.skip_ld = 1'b1;
        end
        REG_AVERAGE_SAMPLES: begin
          cfg_d.avg_len   = wlen;
          cfg_ld_o.avg_ld = 1'b1;
        end
        REG_EMA_ALPHA:     cfg_d.alpha     = walpha;
        REG_FIT_SLOPE:     cfg_d.slope     = cfg_data_i;
        REG_FIT_INTERCEPT: cfg_d.intercept = cfg_data_i;
        REG_OFFSET_ADD:    cfg_d.offset    = cfg_data_i;
        REG_CLAMP_MIN:     cfg_d.clamp_min = cfg_data_i;
        REG_CLAMP_MAX:     cfg_d.clamp_max = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/ssfc_alu.sv]
`default_nettype none

module ssfc_alu (
  input  ssfc_pkg::alu_req_t          req_i,
  output logic [ssfc_pkg::AluW-1:0]   res_o
);
  import ssfc_pkg::*;

  logic [AluW-1:0] b_inv;

  // two's complement add or subtract
  assign b_inv = req_i.b ^ {AluW{req_i.sub}};
  assign res_o = req_i.a + b_inv + AluW'(req_i.sub);

endmodule

`default_nettype wire

[hdl/ssfc_seq.sv]
`default_nettype none

`include "sensor_sample_filter_chain_top_macros.svh"

module ssfc_seq #(
  parameter int unsigned PASS_FIRST    = ssfc_pkg::PassFirstDef,
  parameter int unsigned SAMPLE_BITS   = ssfc_pkg::SampleBitsDef,
  parameter int unsigned FRACTION_BITS = ssfc_pkg::FractionBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [ssfc_pkg::SmpW-1:0]  sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ssfc_pkg::SmpW-1:0]  filtered_value_o,
  input  ssfc_pkg::cfg_t                    cfg_i,
  input  ssfc_pkg::cfg_ld_t                 cfg_ld_i,
  output ssfc_pkg::alu_req_t                alu_req_o,
  input  logic [ssfc_pkg::AluW-1:0]         alu_res_i
);
  import ssfc_pkg::*;

  // saturation bounds
  localparam int unsigned SatW = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam logic signed [AluW-1:0] SatHi =
    signed'((AluW'(1) << (SatW - 1)) - AluW'(1));
  localparam logic signed [AluW-1:0] SatLo = ~SatHi;

  // step counter
  localparam int unsigned CntW = $clog2(SmpW);
  localparam logic [CntW-1:0] DivLast = CntW'(SmpW - 1);
  localparam logic [CntW-1:0] EmaLast = CntW'(AlphaW - 1);
  localparam logic [CntW-1:0] FitLast = CntW'(SmpW - 1);
  localparam int unsigned EmaShift = AlphaW - 1;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_ABS  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_NEG  = 4'd4;
  localparam logic [3:0] S_EMA  = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_EMUL = 4'd7;
  localparam logic [3:0] S_EADD = 4'd8;
  localparam logic [3:0] S_FSET = 4'd9;
  localparam logic [3:0] S_FMUL = 4'd10;
  localparam logic [3:0] S_FADD = 4'd11;
  localparam logic [3:0] S_OFF  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]      state_q, state_d;
  logic [LenW-1:0] skip_left_q, skip_left_d;
  logic [LenW-1:0] avg_left_q, avg_left_d;
  logic [SumW-1:0] avg_sum_q, avg_sum_d;
  logic [SmpW-1:0] ema_prev_q, ema_prev_d;
  logic            ema_seeded_q, ema_seeded_d;
  logic            first_pend_q, first_pend_d;
  logic [SmpW-1:0] smp_q, smp_d;
  logic [SmpW-1:0] val_q, val_d;
  logic [SumW-1:0] rq_q, rq_d;
  logic            neg_q, neg_d;
  logic [AluW-1:0] acc_q, acc_d;
  logic [AluW-1:0] mcand_q, mcand_d;
  logic [SmpW-1:0] mplier_q, mplier_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_vld_q, out_vld_d;
  logic [SmpW-1:0] out_q, out_d;

  logic            out_free;
  logic            div_ge;
  logic [SmpW-1:0] clamp_lo;
  logic [SmpW-1:0] clamped;

  function automatic logic [AluW-1:0] sx(input logic [SmpW-1:0] x);
    return {{(AluW - SmpW){x[SmpW-1]}}, x};
  endfunction

  function automatic logic [AluW-1:0] sx_sum(input logic [SumW-1:0] x);
    return {{(AluW - SumW){x[SumW-1]}}, x};
  endfunction

  function automatic logic [SmpW-1:0] sat_f(input logic [AluW-1:0] v);
    logic signed [AluW-1:0] vs;
    vs = signed'(v);
    if (vs > SatHi) begin
      return SatHi[SmpW-1:0];
    end else if (vs < SatLo) begin
      return SatLo[SmpW-1:0];
    end
    return v[SmpW-1:0];
  endfunction

  // lower bound first, upper bound last
  assign clamp_lo = (signed'(val_q) < signed'(cfg_i.clamp_min)) ? cfg_i.clamp_min : val_q;
  assign clamped  = (signed'(clamp_lo) > signed'(cfg_i.clamp_max)) ? cfg_i.clamp_max
                                                                    : clamp_lo;

  assign out_free = !out_vld_q || !out_stall_i;
  assign div_ge   = !alu_res_i[AluW-1];

  // sequencer and datapath
  always_comb begin
    state_d      = state_q;
    skip_left_d  = skip_left_q;
    avg_left_d   = avg_left_q;
    avg_sum_d    = avg_sum_q;
    ema_prev_d   = ema_prev_q;
    ema_seeded_d = ema_seeded_q;
    first_pend_d = first_pend_q;
    smp_d        = smp_q;
    val_d        = val_q;
    rq_d         = rq_q;
    neg_d        = neg_q;
    acc_d        = acc_q;
    mcand_d      = mcand_q;
    mplier_d     = mplier_q;
    cnt_d        = cnt_q;
    out_vld_d    = out_vld_q;
    out_d        = out_q;
    alu_req_o    = '0;

    // result taken downstream
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q) inside
      S_IDLE: begin
        if (in_valid_i) begin
          if (skip_left_q != '0) begin
            skip_left_d = skip_left_q - LenW'(1);
          end else begin
            smp_d   = sample_i;
            state_d = S_ACC;
          end
        end
      end
      S_ACC: begin
        alu_req_o.a = sx_sum(avg_sum_q);
        alu_req_o.b = sx(smp_q);
        if (avg_left_q <= LenW'(1)) begin
          avg_sum_d  = '0;
          avg_left_d = cfg_i.avg_len;
          if (cfg_i.avg_len == LenW'(1)) begin
            val_d   = alu_res_i[SmpW-1:0];
            state_d = S_EMA;
          end else begin
            rq_d    = alu_res_i[SumW-1:0];
            neg_d   = alu_res_i[SumW-1];
            state_d = S_ABS;
          end
        end else begin
          avg_sum_d  = alu_res_i[SumW-1:0];
          avg_left_d = avg_left_q - LenW'(1);
          state_d    = S_IDLE;
        end
      end
      S_ABS: begin
        // magnitude of the block sum
        alu_req_o.b   = sx_sum(rq_q);
        alu_req_o.sub = neg_q;
        rq_d          = alu_res_i[SumW-1:0];
        cnt_d         = '0;
        state_d       = S_DIV;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per step
        alu_req_o.a   = AluW'(rq_q[SumW-1:SmpW-1]);
        alu_req_o.b   = AluW'(cfg_i.avg_len);
        alu_req_o.sub = 1'b1;
        rq_d = {(div_ge ? alu_res_i[LenW-1:0] : rq_q[SumW-2:SmpW-1]),
                rq_q[SmpW-2:0], div_ge};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == DivLast) begin
          state_d = S_NEG;
        end
      end
      S_NEG: begin
        // restore the sign, truncating toward zero
        alu_req_o.b   = AluW'(rq_q[SmpW-1:0]);
        alu_req_o.sub = neg_q;
        val_d         = alu_res_i[SmpW-1:0];
        state_d       = S_EMA;
      end
      S_EMA: begin
        if (!ema_seeded_q) begin
          ema_prev_d   = val_q;
          ema_seeded_d = 1'b1;
        end
        if (first_pend_q) begin
          first_pend_d = 1'b0;
          state_d      = S_FSET;
        end else begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        alu_req_o.a   = sx(val_q);
        alu_req_o.b   = sx(ema_prev_q);
        alu_req_o.sub = 1'b1;
        mcand_d       = alu_res_i;
        acc_d         = '0;
        mplier_d      = SmpW'(cfg_i.alpha);
        cnt_d         = '0;
        state_d       = S_EMUL;
      end
      S_EMUL, S_FMUL: begin
        // shift and add; the calibration multiplier is signed so its top bit subtracts
        alu_req_o.a   = acc_q;
        alu_req_o.b   = mcand_q;
        alu_req_o.sub = (state_q == S_FMUL) && (cnt_q == FitLast);
        if (mplier_q[0]) begin
          acc_d = alu_res_i;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CntW'(1);
        if ((state_q == S_EMUL) && (cnt_q == EmaLast)) begin
          state_d = S_EADD;
        end
        if ((state_q == S_FMUL) && (cnt_q == FitLast)) begin
          state_d = S_FADD;
        end
      end
      S_EADD: begin
        alu_req_o.a = sx(ema_prev_q);
        alu_req_o.b = AluW'(signed'(acc_q) >>> EmaShift);
        val_d       = alu_res_i[SmpW-1:0];
        ema_prev_d  = alu_res_i[SmpW-1:0];
        state_d     = S_FSET;
      end
      S_FSET: begin
        mcand_d  = sx(cfg_i.slope);
        mplier_d = val_q;
        acc_d    = '0;
        cnt_d    = '0;
        state_d  = S_FMUL;
      end
      S_FADD: begin
        alu_req_o.a = AluW'(signed'(acc_q) >>> FRACTION_BITS);
        alu_req_o.b = sx(cfg_i.intercept);
        val_d       = sat_f(alu_res_i);
        state_d     = S_OFF;
      end
      S_OFF: begin
        alu_req_o.a = sx(val_q);
        alu_req_o.b = sx(cfg_i.offset);
        val_d       = sat_f(alu_res_i);
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = clamped;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // counter reloads from register writes
    if (cfg_ld_i.skip_ld) begin
      skip_left_d = cfg_ld_i.skip_val;
    end
    if (cfg_ld_i.avg_ld) begin
      avg_left_d = cfg_ld_i.avg_len;
      avg_sum_d  = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      skip_left_q  <= '0;
      avg_left_q   <= LenW'(1);
      avg_sum_q    <= '0;
      ema_prev_q   <= '0;
      ema_seeded_q <= 1'b0;
      first_pend_q <= 1'(PASS_FIRST);
      cnt_q        <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      skip_left_q  <= skip_left_d;
      avg_left_q   <= avg_left_d;
      avg_sum_q    <= avg_sum_d;
      ema_prev_q   <= ema_prev_d;
      ema_seeded_q <= ema_seeded_d;
      first_pend_q <= first_pend_d;
      cnt_q        <= cnt_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    smp_q    <= smp_d;
    val_q    <= val_d;
    rq_q     <= rq_d;
    neg_q    <= neg_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    out_q    <= out_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_vld_q;
  assign filtered_value_o = signed'(out_q);

  // checks
  `SSFC_ASSERT(a_skip_no_work, (state_q == S_IDLE && in_valid_i && skip_left_q != '0) |=> (state_q == S_IDLE), "skipped sample started work")
  `SSFC_ASSERT(a_partial_block, (state_q == S_ACC && avg_left_q > LenW'(1)) |=> (state_q == S_IDLE), "partial block went past the average")
  `SSFC_ASSERT(a_out_from_final, $rose(out_vld_q) |-> ($past(state_q) == S_OUT), "result raised outside the final step")
  `SSFC_ASSERT(a_pass_after_seed, $fell(first_pend_q) |-> ema_seeded_q, "first pass cleared before seeding")
  `SSFC_ASSERT_ANY(a_rst_no_out, !rst_ni |-> !out_vld_q, "result valid during reset")

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import ssfc_pkg::*;

  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned HoldCycles  = 500;

  localparam int unsigned PassFirst  = PassFirstDef;
  localparam int unsigned SampleBits = SampleBitsDef;
  localparam int unsigned FracBits   = FractionBitsDef;
  localparam int unsigned SatBits    = (SampleBits < 32) ? SampleBits : 32;

  localparam longint WordMax = (longint'(1) <<< (SatBits - 1)) - 1;
  localparam longint WordMin = -WordMax - 1;

  localparam logic signed [SmpW-1:0] SmpMax = 32'sh7FFF_FFFF;
  localparam logic signed [SmpW-1:0] SmpMin = 32'sh8000_0000;
  localparam logic signed [SmpW-1:0] SmpOne = 32'sh0001_0000;

  // register indexes with nothing behind them
  localparam logic [CfgIdxW-1:0] RegFirstUnused = 4'd8;
  localparam logic [CfgIdxW-1:0] RegLastUnused  = 4'hF;

  // dut connections
  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [CfgIdxW-1:0]        cfg_index   = '0;
  logic [SmpW-1:0]           cfg_data    = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic signed [SmpW-1:0]    sample_in   = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic signed [SmpW-1:0]    filtered_value;

  // traffic shaping and bookkeeping
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_cycles   = 0;
  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;

  // expected filtered values, oldest first
  logic signed [SmpW-1:0] pending_filtered[$];
  logic signed [SmpW-1:0] oldest_filtered;

  // settings copy
  logic [LenW-1:0]        cfg_skip;
  logic [LenW-1:0]        cfg_block_len;
  logic [AlphaW-1:0]      cfg_alpha;
  logic signed [SmpW-1:0] cfg_slope;
  logic signed [SmpW-1:0] cfg_intercept;
  logic signed [SmpW-1:0] cfg_offset;
  logic signed [SmpW-1:0] cfg_lo;
  logic signed [SmpW-1:0] cfg_hi;

  // chain state copy
  logic [LenW-1:0]        skip_remaining;
  logic [LenW-1:0]        block_remaining;
  logic signed [SumW-1:0] block_sum;
  logic signed [SmpW-1:0] ema_last;
  logic                   ema_started;
  logic                   pass_first_open;

  sensor_sample_filter_chain_top #(
    .PASS_FIRST   (PassFirst),
    .SAMPLE_BITS  (SampleBits),
    .FRACTION_BITS(FracBits)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .sample_i        (sample_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .filtered_value_o(filtered_value)
  );

  // clock
  initial begin
    forever #(HalfPeriod) clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic [LenW-1:0] eff_block_len();
    return (cfg_block_len == '0) ? LenW'(1) : cfg_block_len;
  endfunction

  function automatic longint saturate_word(input longint v);
    if (v > WordMax) return WordMax;
    if (v < WordMin) return WordMin;
    return v;
  endfunction

  task automatic reset_prediction();
    cfg_skip        = '0;
    cfg_block_len   = LenW'(1);
    cfg_alpha       = AlphaOne;
    cfg_slope       = SmpOne;
    cfg_intercept   = '0;
    cfg_offset      = '0;
    cfg_lo          = SmpMin;
    cfg_hi          = SmpMax;
    skip_remaining  = cfg_skip;
    block_remaining = eff_block_len();
    block_sum       = '0;
    ema_last        = '0;
    ema_started     = 1'b0;
    pass_first_open = (PassFirst != 0);
  endtask

  task automatic apply_register(input logic [CfgIdxW-1:0] index,
                                input logic [SmpW-1:0] value);
    case (index)
      REG_SKIP_COUNT: begin
        cfg_skip       = value[LenW-1:0];
        skip_remaining = cfg_skip;
      end
      REG_AVERAGE_SAMPLES: begin
        cfg_block_len   = value[LenW-1:0];
        block_remaining = eff_block_len();
        block_sum       = '0;
      end
      REG_EMA_ALPHA:     cfg_alpha     = value[AlphaW-1:0];
      REG_FIT_SLOPE:     cfg_slope     = value;
      REG_FIT_INTERCEPT: cfg_intercept = value;
      REG_OFFSET_ADD:    cfg_offset    = value;
      REG_CLAMP_MIN:     cfg_lo        = value;
      REG_CLAMP_MAX:     cfg_hi        = value;
      default: ;
    endcase
  endtask

  // runs one accepted sample through the chain copy
  task automatic condition_sample(input logic signed [SmpW-1:0] raw);
    longint v;
    longint weight;
    // dropped while skipping
    if (skip_remaining != 0) begin
      skip_remaining--;
      return;
    end
    // block average, mean truncated toward zero
    block_sum = block_sum + raw;
    if (block_remaining != 0) block_remaining--;
    if (block_remaining != 0) return;
    v               = longint'(block_sum) / longint'(eff_block_len());
    block_sum       = '0;
    block_remaining = eff_block_len();
    // moving average seeded by its first input
    if (!ema_started) begin
      ema_last    = v[SmpW-1:0];
      ema_started = 1'b1;
    end
    if (pass_first_open) begin
      pass_first_open = 1'b0;
    end else begin
      weight   = (cfg_alpha > AlphaOne) ? longint'(AlphaOne) : longint'(cfg_alpha);
      v        = longint'(ema_last) + ((weight * (v - longint'(ema_last))) >>> (AlphaW - 1));
      ema_last = v[SmpW-1:0];
    end
    // calibration and offset, both saturating
    v = saturate_word(((longint'(cfg_slope) * v) >>> FracBits) + longint'(cfg_intercept));
    v = saturate_word(v + longint'(cfg_offset));
    // lower bound first, upper bound wins
    if (v < longint'(cfg_lo)) v = longint'(cfg_lo);
    if (v > longint'(cfg_hi)) v = longint'(cfg_hi);
    pending_filtered.push_back(v[SmpW-1:0]);
  endtask

  // ---------------------------------------------------------------------------
  // output side: check each transaction, then pick the next stall
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_filtered.size() == 0) begin
        $display("%0t: unexpected filtered_value, expected none, got %0d",
                 $time, filtered_value);
        error_count++;
      end else begin
        oldest_filtered = pending_filtered.pop_front();
        if (filtered_value !== oldest_filtered) begin
          $display("%0t: filtered_value mismatch, expected %0d, got %0d",
                   $time, oldest_filtered, filtered_value);
          error_count++;
        end
      end
    end
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [SmpW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_register(index, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [SmpW-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    sample_in <= value;
    do @(posedge clk); while (in_stall);
    condition_sample(value);
  endtask

  task automatic stop_samples();
    in_valid <= 1'b0;
  endtask

  // all results in, then room for a sample that yields none
  task automatic wait_idle();
    stop_samples();
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [SmpW-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return SmpMax;
      1:       return SmpMin;
      2:       return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      3:       return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return $urandom();
    endcase
  endfunction

  // mostly short blocks and mild calibration, now and then anything
  task automatic randomize_settings();
    logic [SmpW-1:0] noise;
    logic [SmpW-1:0] lo;
    logic [SmpW-1:0] hi;
    logic [SmpW-1:0] swap;
    noise = $urandom() & 32'hFFFF_0000;
    write_register(REG_SKIP_COUNT,
                   noise | (($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0));
    case ($urandom_range(7))
      0:       write_register(REG_AVERAGE_SAMPLES, noise);
      1, 2:    write_register(REG_AVERAGE_SAMPLES, noise | $urandom_range(2, 4));
      3:       write_register(REG_AVERAGE_SAMPLES, noise | $urandom_range(5, 8));
      default: write_register(REG_AVERAGE_SAMPLES, noise | 1);
    endcase
    noise = $urandom() & 32'hFFFE_0000;
    case ($urandom_range(3))
      0:       write_register(REG_EMA_ALPHA, noise | AlphaOne);
      2:       write_register(REG_EMA_ALPHA, noise | $urandom_range(32'h1_0001, 32'h1_FFFF));
      default: write_register(REG_EMA_ALPHA, noise | $urandom_range(0, 32'h1_0000));
    endcase
    write_register(REG_FIT_SLOPE, ($urandom_range(3) == 0) ?
                   $urandom() : $urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
    write_register(REG_FIT_INTERCEPT, ($urandom_range(3) == 0) ?
                   $urandom() : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
    write_register(REG_OFFSET_ADD, ($urandom_range(3) == 0) ?
                   $urandom() : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
    lo = $urandom();
    hi = $urandom();
    case ($urandom_range(3))
      0: begin
        lo = SmpMin;
        hi = SmpMax;
      end
      1: ; // bounds may come out crossed
      default: begin
        if ($signed(lo) > $signed(hi)) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
      end
    endcase
    write_register(REG_CLAMP_MIN, lo);
    write_register(REG_CLAMP_MAX, hi);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings pass samples straight through
  task automatic test_reset_passthrough();
    send_sample(SmpMax);
    send_sample(SmpMin);
    send_sample('0);
    send_sample(-SmpOne);
    wait_idle();
  endtask

  // skip, block average, register reloads, zero block length
  task automatic test_skip_and_average();
    write_register(REG_SKIP_COUNT, 32'd2);
    write_register(REG_AVERAGE_SAMPLES, 32'd3);
    send_sample(SmpMax);
    send_sample(SmpMin);
    // mean of -2/3 truncates to zero
    send_sample(-32'sd2);
    send_sample('0);
    send_sample('0);
    wait_idle();
    write_register(REG_SKIP_COUNT, 32'd65535);
    send_sample(SmpOne);
    wait_idle();
    write_register(REG_SKIP_COUNT, 32'd0);
    // a partial block is dropped by the reload
    write_register(REG_AVERAGE_SAMPLES, 32'd65535);
    send_sample(SmpMax);
    wait_idle();
    write_register(REG_AVERAGE_SAMPLES, 32'd0);
    send_sample(SmpOne);
    wait_idle();
    // widest block sums
    write_register(REG_AVERAGE_SAMPLES, 32'd2);
    send_sample(SmpMax);
    send_sample(SmpMax);
    send_sample(SmpMin);
    send_sample(SmpMin);
    wait_idle();
    write_register(REG_AVERAGE_SAMPLES, 32'd1);
  endtask

  // half weight, weight above one, zero weight
  task automatic test_moving_average();
    write_register(REG_EMA_ALPHA, 32'h0000_8000);
    send_sample(SmpMax);
    send_sample(-SmpOne);
    wait_idle();
    write_register(REG_EMA_ALPHA, 32'h0001_FFFF);
    send_sample(32'sh0003_4000);
    wait_idle();
    write_register(REG_EMA_ALPHA, 32'h0000_0000);
    send_sample(SmpMin);
    wait_idle();
    write_register(REG_EMA_ALPHA, AlphaOne);
  endtask

  // calibration saturating both ways, offset saturating high
  task automatic test_saturation();
    write_register(REG_FIT_SLOPE, SmpMax);
    write_register(REG_FIT_INTERCEPT, SmpMax);
    send_sample(SmpMax);
    wait_idle();
    write_register(REG_FIT_SLOPE, SmpMin);
    write_register(REG_FIT_INTERCEPT, SmpMin);
    send_sample(SmpMax);
    wait_idle();
    write_register(REG_FIT_SLOPE, SmpOne);
    write_register(REG_FIT_INTERCEPT, '0);
    write_register(REG_OFFSET_ADD, SmpMax);
    send_sample(SmpMax);
    wait_idle();
    write_register(REG_OFFSET_ADD, '0);
  endtask

  // crossed bounds, then ordinary bounds
  task automatic test_clamp();
    write_register(REG_CLAMP_MIN, 32'sh0064_0000);
    write_register(REG_CLAMP_MAX, 32'shFFFB_0000);
    send_sample('0);
    wait_idle();
    write_register(REG_CLAMP_MIN, -SmpOne);
    write_register(REG_CLAMP_MAX, SmpOne);
    send_sample(SmpMax);
    send_sample(SmpMin);
    wait_idle();
    write_register(REG_CLAMP_MIN, SmpMin);
    write_register(REG_CLAMP_MAX, SmpMax);
  endtask

  // writes to unmapped indexes change nothing
  task automatic test_unused_index();
    write_register(RegFirstUnused, $urandom());
    write_register(RegLastUnused, $urandom());
    send_sample(32'sh1234_5678);
    wait_idle();
  endtask

  // long receiver hold-off while samples keep coming
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    randomize_settings();
    write_register(REG_SKIP_COUNT, 32'd0);
    write_register(REG_AVERAGE_SAMPLES, 32'd1);
    hold_cycles = HoldCycles;
    repeat (12) send_sample(pick_sample());
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned out_stall_pct,
                                     input int unsigned count);
    send_idle_pct = idle_pct;
    stall_pct     = out_stall_pct;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        wait_idle();
        randomize_settings();
      end
      send_sample(pick_sample());
    end
    wait_idle();
  endtask

  // sequence
  initial begin
    reset_prediction();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_skip_and_average();
    test_moving_average();
    test_saturation();
    test_clamp();
    test_unused_index();
    test_output_backpressure();
    test_random_traffic(0, 0, 170);
    test_random_traffic(85, 0, 170);
    test_random_traffic(0, 85, 160);
    test_random_traffic(36, 36, 160);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/ssfc_pkg.sv
hdl/ssfc_cfg_regs.sv
hdl/ssfc_alu.sv
hdl/ssfc_seq.sv
hdl/sensor_sample_filter_chain_top.sv
tb/tb.sv
